// ----- sv/clrf_pkg.sv -----
// Shared types and constants for the C literal rewrite filter.
// Holds lexer mode codes, character constants and the controller/datapath structs.
// No dependencies.
package clrf_pkg;

  localparam int VALUE_WIDTH_DEF = 32;

  typedef enum logic [3:0] {
    M_NORMAL = 4'd0,
    M_STR    = 4'd1,
    M_STRESC = 4'd2,
    M_SLASH  = 4'd3,
    M_COMM   = 4'd4,
    M_STAR   = 4'd5,
    M_NUM    = 4'd6,
    M_ZERO   = 4'd7,
    M_WORD   = 4'd8,
    M_BIN    = 4'd9,
    M_HEX    = 4'd10
  } lex_mode_t;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LX     = 8'h78;
  localparam logic [7:0] CH_UX     = 8'h58;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_UB     = 8'h42;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LZ     = 8'h7a;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_UZ     = 8'h5a;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // take in_byte this cycle
    logic emit_x;     // send the 'x' of a hex literal
    logic dig_step;   // consume one digit slot
    logic dig_emit;   // the consumed digit is sent
    logic emit_tail;  // send the byte that ended the literal
  } clrf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic free;         // output register can take an item
    logic step_digits;  // incoming byte ends a binary or hex literal
    logic step_hex;     // that literal is hex
    logic dig_skip;     // current digit is a leading zero
    logic cnt_zero;     // current digit is the last one
  } clrf_stat_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    hex_char = (d < 4'd10) ? (CH_ZERO + {4'd0, d}) : (CH_LA + {4'd0, d} - 8'd10);
  endfunction

endpackage

// ----- sv/clrf_ctrl.sv -----
// Controller for the C literal rewrite filter: input handshake and digit sequencing.
// Depends on clrf_pkg.
module clrf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  clrf_pkg::clrf_stat_t stat,
  output clrf_pkg::clrf_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_XPRE,
    S_DIG,
    S_TAIL
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall   = !stat.free;
        cmd.accept = in_valid && stat.free;
        if (cmd.accept && stat.step_digits) begin
          state_nxt = stat.step_hex ? S_XPRE : S_DIG;
        end
      end
      S_XPRE: begin
        cmd.emit_x = stat.free;
        if (stat.free) state_nxt = S_DIG;
      end
      S_DIG: begin
        cmd.dig_step = stat.dig_skip || stat.free;
        cmd.dig_emit = !stat.dig_skip && stat.free;
        if (cmd.dig_step && stat.cnt_zero) state_nxt = S_TAIL;
      end
      S_TAIL: begin
        cmd.emit_tail = stat.free;
        if (stat.free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/clrf_dp.sv -----
// Datapath for the C literal rewrite filter: lexer state, literal value,
// digit shifter and output register. Depends on clrf_pkg.
module clrf_dp #(
  parameter int VALUE_WIDTH = clrf_pkg::VALUE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           in_byte,
  input  clrf_pkg::clrf_cmd_t  cmd,
  output clrf_pkg::clrf_stat_t stat,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [7:0]           out_byte,
  output logic                 out_last
);

  localparam int ODIG = (VALUE_WIDTH + 2) / 3;
  localparam int HDIG = (VALUE_WIDTH + 3) / 4;
  localparam int OW   = 3 * ODIG;
  localparam int HW   = 4 * HDIG;
  localparam int SW   = (OW > HW) ? OW : HW;
  localparam int CNTW = $clog2(ODIG);

  clrf_pkg::lex_mode_t    mode_r, mode_nxt;
  logic                   quote_r, quote_nxt;
  logic [VALUE_WIDTH-1:0] value_r, value_nxt;
  logic [7:0]             byte_r;
  logic [SW-1:0]          sh_r;
  logic [CNTW-1:0]        cnt_r;
  logic                   started_r;
  logic                   hex_r;
  logic                   out_valid_r;
  logic [7:0]             out_byte_r;
  logic                   out_last_r;

  logic       is_alpha, is_digit, is_hexl, is_hexu, hex_ok;
  logic [3:0] hex_v;
  logic       emit, again, digits, hex_end;
  logic [3:0] dig;
  logic [7:0] dig_char;
  logic       out_load;

  assign is_alpha = (in_byte >= clrf_pkg::CH_LA && in_byte <= clrf_pkg::CH_LZ) ||
                    (in_byte >= clrf_pkg::CH_UA && in_byte <= clrf_pkg::CH_UZ);
  assign is_digit = in_byte >= clrf_pkg::CH_ZERO && in_byte <= clrf_pkg::CH_NINE;
  assign is_hexl  = in_byte >= clrf_pkg::CH_LA && in_byte <= clrf_pkg::CH_LF;
  assign is_hexu  = in_byte >= clrf_pkg::CH_UA && in_byte <= clrf_pkg::CH_UF;
  assign hex_ok   = is_digit || is_hexl || is_hexu;
  // letters a-f / A-F: low nibble 1..6 maps to 10..15
  assign hex_v    = is_digit ? in_byte[3:0] : (in_byte[3:0] + 4'd9);

  // one lexer step on in_byte
  always_comb begin
    mode_nxt  = mode_r;
    quote_nxt = quote_r;
    value_nxt = value_r;
    emit      = 1'b0;
    again     = 1'b0;
    digits    = 1'b0;
    hex_end   = 1'b0;
    unique case (mode_r)
      clrf_pkg::M_ZERO: begin
        if (is_digit || in_byte == clrf_pkg::CH_DOT) begin
          emit     = 1'b1;
          mode_nxt = clrf_pkg::M_NUM;
        end else if (in_byte == clrf_pkg::CH_LX || in_byte == clrf_pkg::CH_UX) begin
          value_nxt = '0;
          mode_nxt  = clrf_pkg::M_HEX;
        end else if (in_byte == clrf_pkg::CH_LB || in_byte == clrf_pkg::CH_UB) begin
          mode_nxt = clrf_pkg::M_BIN;
        end else begin
          again = 1'b1;
        end
      end
      clrf_pkg::M_NUM: begin
        if (is_digit || in_byte == clrf_pkg::CH_DOT) emit = 1'b1;
        else again = 1'b1;
      end
      clrf_pkg::M_BIN: begin
        if (is_digit) begin
          value_nxt = {value_r[VALUE_WIDTH-2:0], 1'b0} + VALUE_WIDTH'(in_byte[3:0]);
        end else begin
          digits = 1'b1;
          again  = 1'b1;
        end
      end
      clrf_pkg::M_HEX: begin
        if (hex_ok) begin
          value_nxt = {value_r[VALUE_WIDTH-5:0], 4'd0} + VALUE_WIDTH'(hex_v);
        end else begin
          digits  = 1'b1;
          hex_end = 1'b1;
          again   = 1'b1;
        end
      end
      clrf_pkg::M_STR: begin
        emit = 1'b1;
        if (in_byte == clrf_pkg::CH_DQUOTE || in_byte == clrf_pkg::CH_SQUOTE) begin
          if ((in_byte == clrf_pkg::CH_DQUOTE) == quote_r) mode_nxt = clrf_pkg::M_NORMAL;
        end else if (in_byte == clrf_pkg::CH_BSLASH) begin
          mode_nxt = clrf_pkg::M_STRESC;
        end
      end
      clrf_pkg::M_STRESC: begin
        emit     = 1'b1;
        mode_nxt = clrf_pkg::M_STR;
      end
      clrf_pkg::M_SLASH: begin
        emit     = 1'b1;
        mode_nxt = (in_byte == clrf_pkg::CH_STAR) ? clrf_pkg::M_COMM : clrf_pkg::M_NORMAL;
      end
      clrf_pkg::M_COMM: begin
        emit = 1'b1;
        if (in_byte == clrf_pkg::CH_STAR) mode_nxt = clrf_pkg::M_STAR;
      end
      clrf_pkg::M_STAR: begin
        emit     = 1'b1;
        mode_nxt = (in_byte == clrf_pkg::CH_SLASH) ? clrf_pkg::M_NORMAL : clrf_pkg::M_COMM;
      end
      clrf_pkg::M_WORD: begin
        if (is_alpha || is_digit || in_byte == clrf_pkg::CH_UNDER) emit = 1'b1;
        else again = 1'b1;
      end
      default: again = 1'b1;  // normal mode and unused codes
    endcase

    if (again) begin
      emit = 1'b1;
      if (is_alpha || in_byte == clrf_pkg::CH_UNDER) begin
        mode_nxt = clrf_pkg::M_WORD;
      end else if (in_byte == clrf_pkg::CH_ZERO) begin
        value_nxt = '0;
        mode_nxt  = clrf_pkg::M_ZERO;
      end else if (is_digit || in_byte == clrf_pkg::CH_DOT) begin
        mode_nxt = clrf_pkg::M_NUM;
      end else if (in_byte == clrf_pkg::CH_DQUOTE || in_byte == clrf_pkg::CH_SQUOTE) begin
        quote_nxt = (in_byte == clrf_pkg::CH_DQUOTE);
        mode_nxt  = clrf_pkg::M_STR;
      end else if (in_byte == clrf_pkg::CH_SLASH) begin
        mode_nxt = clrf_pkg::M_SLASH;
      end else begin
        mode_nxt = clrf_pkg::M_NORMAL;
      end
    end
  end

  // digit under the scan head
  assign dig      = hex_r ? sh_r[HW-1 -: 4] : {1'b0, sh_r[OW-1 -: 3]};
  assign dig_char = hex_r ? clrf_pkg::hex_char(dig) : (clrf_pkg::CH_ZERO + {4'd0, dig});

  assign stat.free        = !out_valid_r || !out_stall;
  assign stat.step_digits = digits;
  assign stat.step_hex    = hex_end;
  assign stat.dig_skip    = (dig == 4'd0) && !started_r && (cnt_r != '0);
  assign stat.cnt_zero    = (cnt_r == '0);

  // output register takes a new item this cycle
  assign out_load = (cmd.accept && !digits && emit) || cmd.emit_x ||
                    cmd.dig_emit || cmd.emit_tail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= clrf_pkg::M_NORMAL;
      quote_r     <= 1'b0;
      value_r     <= '0;
      started_r   <= 1'b0;
      cnt_r       <= '0;
      hex_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      if (cmd.accept) begin
        mode_r  <= mode_nxt;
        quote_r <= quote_nxt;
        value_r <= value_nxt;
        byte_r  <= in_byte;
        if (digits) begin
          sh_r      <= SW'(value_r);
          cnt_r     <= hex_end ? CNTW'(HDIG - 1) : CNTW'(ODIG - 1);
          hex_r     <= hex_end;
          started_r <= 1'b0;
        end else if (emit) begin
          out_byte_r  <= in_byte;
          out_last_r  <= 1'b1;
        end
      end

      if (cmd.emit_x) begin
        out_byte_r  <= clrf_pkg::CH_LX;
        out_last_r  <= 1'b0;
      end

      if (cmd.dig_step) begin
        sh_r  <= hex_r ? (sh_r << 4) : (sh_r << 3);
        cnt_r <= cnt_r - CNTW'(1);
      end

      if (cmd.dig_emit) begin
        started_r   <= 1'b1;
        out_byte_r  <= dig_char;
        out_last_r  <= 1'b0;
      end

      if (cmd.emit_tail) begin
        out_byte_r  <= byte_r;
        out_last_r  <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

// ----- sv/c_literal_rewrite_filter_unit.sv -----
// C literal rewrite filter, top level. A plain byte's item sits in the output register
// in the cycle after accept; throughput one byte per cycle while out_stall is low.
// A byte ending a binary or hex literal is accepted, then 'x' is sent (hex only), then the
// scanner steps through its digit slots (11 octal / 8 hex at 32 bits, leading zeros
// skipped without output) and the ending byte is sent; input stalls meanwhile.
// Reset: synchronous active-low rst_n clears lexer mode, quote flag, value and out_valid.
module c_literal_rewrite_filter_unit #(
  parameter int VALUE_WIDTH = clrf_pkg::VALUE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // source text in
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  // rewritten text out
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  // Controller owns the handshake and sequences the digit scan;
  // datapath holds the lexer state and the one-item output register.
  clrf_pkg::clrf_cmd_t  cmd;
  clrf_pkg::clrf_stat_t stat;

  clrf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Digit scan: the value is copied into a shifter when the literal ends,
  // so the lexer is already free to start the next token with the ending byte.
  clrf_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_byte),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

// ----- sv/clrf_checker.sv -----
// Port-level assertions for the C literal rewrite filter, bound to the top level.
// Depends on clrf_pkg and c_literal_rewrite_filter_unit.
module clrf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // a new byte is only taken once every earlier item is final
  a_no_accept_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !(out_valid && !out_last))
    else $error("byte accepted while a literal burst is open");

  // a non-final item is always part of a rewritten literal
  a_mid_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |->
      (out_byte == clrf_pkg::CH_LX ||
       (out_byte >= clrf_pkg::CH_ZERO && out_byte <= clrf_pkg::CH_NINE) ||
       (out_byte >= clrf_pkg::CH_LA && out_byte <= clrf_pkg::CH_LF)))
    else $error("non-final item is not a literal digit");

  a_mid_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> in_stall)
    else $error("input open during a literal burst");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_byte) && $stable(out_last)))
    else $error("stalled item changed");

  // a stalled input item stays put until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_byte)))
    else $error("stalled input item changed");

endmodule

bind c_literal_rewrite_filter_unit clrf_checker u_clrf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_byte   (in_byte),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .out_last  (out_last)
);
